// ===== src/sli_pkg.sv =====
package sli_pkg;

   // Width of one stored value and of the count field in a result
   localparam int VALUE_W     = 32;
   localparam int COUNT_OUT_W = 5;
   localparam int STATUS_W    = 2;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

   // Command broadcast from the controller to every cell
   typedef struct packed {
      logic                       en;     // apply the update at this edge
      op_type                     op;
      logic signed [VALUE_W-1:0]  value;
      logic                       full;   // insert is refused
      logic                       found;  // remove has a matching entry
   } cmd_type;

endpackage

// ===== src/sli_cell.sv =====
module sli_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                                clock,
   input  sli_pkg::cmd_type                    cmd,
   input  logic [CNT_W-1:0]                    count,
   input  logic                                left_ge,
   input  logic signed [sli_pkg::VALUE_W-1:0]  left_value,
   input  logic signed [sli_pkg::VALUE_W-1:0]  right_value,
   output logic                                ge,
   output logic                                hit,
   output logic signed [sli_pkg::VALUE_W-1:0]  value
);
   import sli_pkg::*;

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      valid;
   logic                      is_tail;
   logic                      ins_here;

   // Local compares: this entry holds a value at or above the item's value
   assign valid    = count > MY_INDEX;
   assign is_tail  = count == MY_INDEX;
   assign ge       = valid && (value_ff >= cmd.value);
   // first entry at or above the value, and equal to it
   assign hit      = ge && !left_ge && (value_ff == cmd.value);
   // insert point: first entry at or above the value, else first free entry
   assign ins_here = !left_ge && (ge || is_tail);

   // Next value: take the new item, shift right on insert, shift left on remove
   always_comb begin
      value_in = value_ff;
      if (cmd.en) begin
         case (cmd.op)
            OP_INSERT: begin
               if (!cmd.full) begin
                  if (ins_here) begin
                     value_in = cmd.value;
                  end else if (left_ge) begin
                     value_in = left_value;
                  end
               end
            end
            OP_REMOVE: begin
               if (cmd.found && ge) begin
                  value_in = right_value;
               end
            end
            default: value_in = value_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== src/sorted_list_insert_remove.sv =====
// Sorted store of signed 32-bit values held in a row of CAPACITY cells.
// The edge that accepts an item sets busy, and the result strobe is registered from busy.
// No new item is taken while busy is high; busy is high for the one cycle in which
// every cell compares against the item and updates at once.
// Reset: synchronous; clears the count and control, stored values are left as
// they are. Results cannot be stalled by the receiver.
module sorted_list_insert_remove #(
   parameter int CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic signed [sli_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_strobe,
   output logic [sli_pkg::STATUS_W-1:0]        rsp_status,
   output logic [sli_pkg::COUNT_OUT_W-1:0]     rsp_entry_count,
   output logic signed [sli_pkg::VALUE_W-1:0]  rsp_smallest
);
   import sli_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   logic                      busy_ff;
   op_type                    op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      strobe_ff;
   status_type                status_ff, status_in;

   cmd_type                   cmd;
   logic [CAPACITY-1:0]       cell_ge;
   logic [CAPACITY-1:0]       cell_hit;
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

   // Command to the cells
   assign cmd.en    = busy_ff;
   assign cmd.op    = op_ff;
   assign cmd.value = value_ff;
   assign cmd.full  = count_ff == CAP_COUNT;
   assign cmd.found = |cell_hit;

   // Row of cells, each linked to its neighbours
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      left_ge;
      logic signed [VALUE_W-1:0] left_value;
      logic signed [VALUE_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_ge    = 1'b0;
         assign left_value = '0;
      end else begin : g_mid
         assign left_ge    = cell_ge[i-1];
         assign left_value = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      sli_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .left_ge     (left_ge),
         .left_value  (left_value),
         .right_value (right_value),
         .ge          (cell_ge[i]),
         .hit         (cell_hit[i]),
         .value       (cell_value[i])
      );
   end

   // Count and status for the item in work
   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      if (busy_ff) begin
         case (op_ff)
            OP_INSERT: begin
               if (cmd.full) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_DONE;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               if (cmd.found) begin
                  status_in = ST_DONE;
                  count_in  = count_ff - CNT_W'(1);
               end else begin
                  status_in = ST_MISSING;
               end
            end
            default: status_in = ST_DONE;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         busy_ff   <= start && !busy_ff;
         strobe_ff <= busy_ff;
         count_ff  <= count_in;
      end
   end

   // Item and result payload
   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         op_ff    <= op_type'(req_op);
         value_ff <= req_value;
      end
      status_ff <= status_in;
   end

   assign count_ext       = {{COUNT_OUT_W{1'b0}}, count_ff};
   assign busy            = busy_ff;
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ext[COUNT_OUT_W-1:0];
   assign rsp_smallest    = (count_ff != '0) ? cell_value[0] : '0;

endmodule

// ===== src/sli_checker.sv =====
module sli_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_strobe,
   input logic [sli_pkg::STATUS_W-1:0]        rsp_status,
   input logic [sli_pkg::COUNT_OUT_W-1:0]     rsp_entry_count
);
   import sli_pkg::*;

   // An accepted item makes the block busy for exactly one cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // The busy cycle is followed by the result strobe
   a_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_strobe && !busy)
      else $error("no result after busy cycle");

   // Status is always one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_status == ST_DONE || rsp_status == ST_FULL
                     || rsp_status == ST_MISSING)
      else $error("undefined status code");

   // A refused item leaves the count as it was
   a_refused_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_DONE |-> rsp_entry_count == $past(rsp_entry_count))
      else $error("count changed on a refused item");

endmodule

bind sorted_list_insert_remove sli_checker u_sli_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count)
);
